// File: rtl/keypad_scan_chatter_check_core_assert.svh
// Assertion helpers used by the keypad scan RTL.
`ifndef KEYPAD_SCAN_CHATTER_CHECK_CORE_ASSERT_SVH
`define KEYPAD_SCAN_CHATTER_CHECK_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KSCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keypad scan check failed");

// Consequent must hold in the cycle after the antecedent.
`define KSCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keypad scan check failed");

`endif

// File: rtl/kscc_pkg.sv
package kscc_pkg;

    localparam int PIN_W   = 5;
    localparam int DRIVE_W = 2;
    localparam int KEY_W   = 9;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int PHASE_W = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_SETTLE_TICKS   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_STABLE_SAMPLES = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MULTI_MODE     = 2'd2;

    localparam logic [CFG_W-1:0] SETTLE_RESET = 16'h1000;
    localparam logic [CFG_W-1:0] STABLE_RESET = 16'd500;

    // scan phases
    localparam logic [PHASE_W-1:0] PH_ALL_SETTLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_STABLE     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LINE0      = 2'd2;
    localparam logic [PHASE_W-1:0] PH_LINE1      = 2'd3;

    localparam logic [DRIVE_W-1:0] DRIVE_ALL   = 2'd3;
    localparam logic [DRIVE_W-1:0] DRIVE_LINE0 = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_LINE1 = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NONE     = 9'd0;
    localparam logic [KEY_W-1:0] KEY_EXTRA    = 9'd9;
    localparam logic [KEY_W-1:0] LINE1_OFFSET = 9'd4;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] stable_samples;
        logic             multi_mode;
    } scan_cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_lines;
        logic               result_valid;
        logic [KEY_W-1:0]   key_value;
    } scan_result_t;

    // column number 1..4 for exactly one pressed column, else 0
    function automatic logic [2:0] one_hot_code(input logic [3:0] cols);
        logic [2:0] code;
        begin
            unique case (cols)
                4'b0001: code = 3'd1;
                4'b0010: code = 3'd2;
                4'b0100: code = 3'd3;
                4'b1000: code = 3'd4;
                default: code = 3'd0;
            endcase
            return code;
        end
    endfunction

endpackage

// File: rtl/keypad_scan_chatter_check_core.sv
// Two-line keypad scanner with chatter check. Each transaction on the s_ channel is one
// pin sample (one scan tick) and yields exactly one m_ transaction carrying the scan line
// drive for that tick, a result flag and the key code or key map. One sample is taken per
// clock, sustained while m_ready stays high; its result is presented on the m_ side through
// the input register and then the result register around the phase and counter update.
// With m_ready held low the block holds two transactions before s_ready drops. Configuration
// writes on cfg_wr_en take effect from the next cycle and are meant for idle periods.
module keypad_scan_chatter_check_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [kscc_pkg::PIN_W-1:0]       s_pin_sample,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [kscc_pkg::DRIVE_W-1:0]     m_drive_lines,
    output logic                             m_result_valid,
    output logic [kscc_pkg::KEY_W-1:0]       m_key_value,

    input  logic                             cfg_wr_en,
    input  logic [kscc_pkg::CIDX_W-1:0]      cfg_index,
    input  logic [kscc_pkg::CFG_W-1:0]       cfg_wdata
);

    kscc_pkg::scan_cfg_t    cfg;
    kscc_pkg::scan_result_t step_res;

    logic                         in_valid_reg, in_valid_next;
    logic [kscc_pkg::PIN_W-1:0]   in_pins_reg;
    logic                         out_valid_reg, out_valid_next;
    kscc_pkg::scan_result_t       out_res_reg;
    logic                         step;
    logic                         s_take;

    // the held sample advances whenever the result register is free or draining
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_pins_reg <= s_pin_sample;
        end
        if (step) begin
            out_res_reg <= step_res;
        end
    end

    kscc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kscc_scan #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pins    (in_pins_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign m_valid        = out_valid_reg;
    assign m_drive_lines  = out_res_reg.drive_lines;
    assign m_result_valid = out_res_reg.result_valid;
    assign m_key_value    = out_res_reg.key_value;

endmodule

// File: rtl/kscc_cfg.sv
module kscc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kscc_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [kscc_pkg::CFG_W-1:0]      cfg_wdata,
    output kscc_pkg::scan_cfg_t             cfg
);

    kscc_pkg::scan_cfg_t cfg_reg;
    kscc_pkg::scan_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                kscc_pkg::REG_SETTLE_TICKS:   cfg_next.settle_ticks   = cfg_wdata;
                kscc_pkg::REG_STABLE_SAMPLES: cfg_next.stable_samples = cfg_wdata;
                kscc_pkg::REG_MULTI_MODE:     cfg_next.multi_mode     = cfg_wdata[0];
                default:                      cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks   <= kscc_pkg::SETTLE_RESET;
            cfg_reg.stable_samples <= kscc_pkg::STABLE_RESET;
            cfg_reg.multi_mode     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/kscc_scan.sv
`include "keypad_scan_chatter_check_core_assert.svh"

module kscc_scan #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [kscc_pkg::PIN_W-1:0]    pins,
    input  kscc_pkg::scan_cfg_t           cfg,
    output kscc_pkg::scan_result_t        res
);

    logic [kscc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]      tick_reg, tick_next;
    logic [kscc_pkg::PIN_W-1:0]   ref_reg, ref_next;
    logic [kscc_pkg::PIN_W-1:0]   line0_reg, line0_next;

    logic [COUNTER_BITS-1:0] settle_lim;
    logic [COUNTER_BITS-1:0] stable_lim;
    logic [COUNTER_BITS-1:0] tick_inc;
    logic                    settle_over;
    logic [3:0]              cols0, cols1;
    logic                    extra;
    logic [2:0]              code0, code1;

    // config value clipped to the counter range
    function automatic logic [COUNTER_BITS-1:0] sat_lim(input logic [kscc_pkg::CFG_W-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            if ((w >> COUNTER_BITS) != 32'd0) begin
                return '1;
            end
            return w[COUNTER_BITS-1:0];
        end
    endfunction

    assign settle_lim  = sat_lim(cfg.settle_ticks);
    assign stable_lim  = sat_lim(cfg.stable_samples);
    assign tick_inc    = tick_reg + COUNTER_BITS'(1);
    assign settle_over = (tick_reg >= settle_lim);

    assign cols0 = ~line0_reg[4:1];
    assign cols1 = ~pins[4:1];
    assign extra = ~line0_reg[0];
    assign code0 = kscc_pkg::one_hot_code(cols0);
    assign code1 = kscc_pkg::one_hot_code(cols1);

    always_comb begin
        phase_next       = phase_reg;
        tick_next        = tick_reg;
        ref_next         = ref_reg;
        line0_next       = line0_reg;
        res.drive_lines  = kscc_pkg::DRIVE_ALL;
        res.result_valid = 1'b0;
        res.key_value    = kscc_pkg::KEY_NONE;
        unique case (phase_reg)
            kscc_pkg::PH_STABLE: begin
                if (pins != ref_reg) begin
                    // chatter: abort with an empty result
                    res.result_valid = 1'b1;
                    phase_next       = kscc_pkg::PH_ALL_SETTLE;
                    tick_next        = '0;
                end else if (tick_inc >= stable_lim) begin
                    phase_next = kscc_pkg::PH_LINE0;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                end
            end
            kscc_pkg::PH_LINE0: begin
                res.drive_lines = kscc_pkg::DRIVE_LINE0;
                if (settle_over) begin
                    tick_next  = '0;
                    line0_next = pins;
                    phase_next = kscc_pkg::PH_LINE1;
                end else begin
                    tick_next = tick_inc;
                end
            end
            kscc_pkg::PH_LINE1: begin
                res.drive_lines = kscc_pkg::DRIVE_LINE1;
                if (settle_over) begin
                    tick_next        = '0;
                    res.result_valid = 1'b1;
                    phase_next       = kscc_pkg::PH_ALL_SETTLE;
                    priority if (cfg.multi_mode) begin
                        res.key_value = {extra, cols1, cols0};
                    end else if (code1 != 3'd0) begin
                        res.key_value = kscc_pkg::KEY_W'(code1) + kscc_pkg::LINE1_OFFSET;
                    end else if (extra) begin
                        res.key_value = kscc_pkg::KEY_EXTRA;
                    end else begin
                        res.key_value = kscc_pkg::KEY_W'(code0);
                    end
                end else begin
                    tick_next = tick_inc;
                end
            end
            default: begin
                if (settle_over) begin
                    tick_next  = '0;
                    ref_next   = pins;
                    phase_next = (stable_lim == '0) ? kscc_pkg::PH_LINE0
                                                    : kscc_pkg::PH_STABLE;
                end else begin
                    tick_next = tick_inc;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kscc_pkg::PH_ALL_SETTLE;
            tick_reg  <= '0;
            ref_reg   <= '0;
            line0_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            ref_reg   <= ref_next;
            line0_reg <= line0_next;
        end
    end

    `KSCC_ASSERT_NOW(a_idle_key_zero, aclk, aresetn, !res.result_valid, res.key_value == kscc_pkg::KEY_NONE)
    `KSCC_ASSERT_NEXT(a_chatter_restart, aclk, aresetn, step && phase_reg == kscc_pkg::PH_STABLE && pins != ref_reg, phase_reg == kscc_pkg::PH_ALL_SETTLE && tick_reg == '0)
    `KSCC_ASSERT_NEXT(a_line0_capture, aclk, aresetn, step && phase_reg == kscc_pkg::PH_LINE0 && settle_over, phase_reg == kscc_pkg::PH_LINE1 && tick_reg == '0 && line0_reg == $past(pins))

endmodule
